// ===== design/lsf_pkg.sv =====
package lsf_pkg;

    localparam int MAX_REQUESTERS = 64;
    localparam int REQ_W          = 6;
    localparam int CNT_W          = 8;
    localparam int STAMP_W        = 16;
    localparam int SEAT_W         = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic KIND_SEAT  = 1'b0;
    localparam logic KIND_SERVE = 1'b1;

    typedef enum logic [2:0] {
        ST_SEATED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_FINISHED = 3'd2,
        ST_WAITING  = 3'd3,
        ST_SERVED   = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_REQ   = 2'd0,
        CFG_NUM_SEATS = 2'd1,
        CFG_SVC_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_ctl_sts;

endpackage

// ===== design/lsf_req_if.sv =====
interface lsf_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [lsf_pkg::REQ_W-1:0] requester;

    modport source (output valid, output kind, output requester, input ready);
    modport sink   (input valid, input kind, input requester, output ready);
endinterface

// ===== design/lsf_res_if.sv =====
interface lsf_res_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [lsf_pkg::REQ_W-1:0]  served_requester;
    logic [lsf_pkg::CNT_W-1:0]  served_count;
    logic [lsf_pkg::SEAT_W-1:0] free_seats;
    logic                       all_finished;

    modport source (output valid, output status, output served_requester,
                    output served_count, output free_seats, output all_finished,
                    input ready);
    modport sink   (input valid, input status, input served_requester,
                    input served_count, input free_seats, input all_finished,
                    output ready);
endinterface

// ===== design/lsf_ctrl.sv =====
module lsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lsf_pkg::t_ctl_sts i_sts,
    output lsf_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register can take the transaction
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lsf_dp.sv =====
module lsf_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_kind,
    input  logic [lsf_pkg::REQ_W-1:0]          i_requester,
    input  lsf_pkg::t_ctl_cmd                  i_cmd,
    output lsf_pkg::t_ctl_sts                  o_sts,
    lsf_res_if.source                          o_res
);

    localparam int REQ_W   = lsf_pkg::REQ_W;
    localparam int CNT_W   = lsf_pkg::CNT_W;
    localparam int STAMP_W = lsf_pkg::STAMP_W;
    localparam int SEAT_W  = lsf_pkg::SEAT_W;
    localparam int NREQ    = lsf_pkg::MAX_REQUESTERS;

    // configuration
    logic [SEAT_W-1:0] r_num_req;
    logic [SEAT_W-1:0] r_num_seats;
    logic [CNT_W-1:0]  r_limit;

    // scheduler state
    logic [NREQ-1:0]    r_waiting;
    logic [NREQ-1:0]    r_cnt_valid;
    logic [CNT_W-1:0]   mem_cnt   [NREQ];
    logic [STAMP_W-1:0] mem_stamp [NREQ];
    logic [STAMP_W-1:0] r_arr_ctr;
    logic [SEAT_W-1:0]  r_occ;

    // item and scan accumulators
    logic               r_kind;
    logic [REQ_W-1:0]   r_req;
    logic [REQ_W-1:0]   r_scan_idx;
    logic               r_rd_vld;
    logic [REQ_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   r_cnt_q;
    logic               r_cnt_vld_q;
    logic [STAMP_W-1:0] r_stamp_q;
    logic               r_found;
    logic [REQ_W-1:0]   r_best_idx;
    logic [CNT_W-1:0]   r_best_cnt;
    logic [STAMP_W-1:0] r_best_age;
    logic [SEAT_W-1:0]  r_fc;
    logic [CNT_W-1:0]   r_cap_cnt;

    // result register
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [REQ_W-1:0]   r_out_who;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [SEAT_W-1:0]  r_out_free;
    logic               r_out_fin;

    logic [SEAT_W-1:0]  n_eff;
    logic [CNT_W-1:0]   e_cnt;
    logic [STAMP_W-1:0] e_age;
    logic               e_better;
    logic               seat_ok;
    logic               serve_hit;
    lsf_pkg::t_status   res_status;
    logic [CNT_W-1:0]   new_cnt;
    logic               best_in_use;
    logic               fc_sub;
    logic               fc_add;
    logic [SEAT_W-1:0]  fc_new;
    logic [SEAT_W-1:0]  n_occ;
    logic [SEAT_W-1:0]  free_new;

    assign n_eff = (r_num_req > SEAT_W'(NREQ)) ? SEAT_W'(NREQ) : r_num_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_req   <= SEAT_W'(NREQ);
            r_num_seats <= SEAT_W'(4);
            r_limit     <= CNT_W'(2);
        end else if (i_cfg_we) begin
            unique case (lsf_pkg::t_cfg_idx'(i_cfg_idx))
                lsf_pkg::CFG_NUM_REQ:   r_num_req   <= i_cfg_data[SEAT_W-1:0];
                lsf_pkg::CFG_NUM_SEATS: r_num_seats <= i_cfg_data[SEAT_W-1:0];
                lsf_pkg::CFG_SVC_LIMIT: r_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan read port: one entry per cycle, data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_cnt_q     <= mem_cnt[r_scan_idx];
            r_stamp_q   <= mem_stamp[r_scan_idx];
            r_cnt_vld_q <= r_cnt_valid[r_scan_idx];
            r_rd_idx    <= r_scan_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && serve_hit) begin
            mem_cnt[r_best_idx] <= new_cnt;
        end
        if (i_cmd.commit && seat_ok) begin
            mem_stamp[r_req] <= r_arr_ctr;
        end
    end

    assign e_cnt    = r_cnt_vld_q ? r_cnt_q : '0;
    assign e_age    = r_arr_ctr - r_stamp_q;
    assign e_better = !r_found || (e_cnt < r_best_cnt)
                      || ((e_cnt == r_best_cnt) && (e_age > r_best_age));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_scan_idx <= '0;
            r_found    <= 1'b0;
            r_fc       <= '0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
                r_fc       <= '0;
            end else begin
                if (i_cmd.issue) begin
                    r_scan_idx <= r_scan_idx + REQ_W'(1);
                end
                if (r_rd_vld) begin
                    if (r_waiting[r_rd_idx] && e_better) begin
                        r_found <= 1'b1;
                    end
                    if (({1'b0, r_rd_idx} < n_eff) && (e_cnt >= r_limit)) begin
                        r_fc <= r_fc + SEAT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind <= i_kind;
            r_req  <= i_requester;
        end
        if (r_rd_vld) begin
            if (r_waiting[r_rd_idx] && e_better) begin
                r_best_idx <= r_rd_idx;
                r_best_cnt <= e_cnt;
                r_best_age <= e_age;
            end
            if (r_rd_idx == r_req) begin
                r_cap_cnt <= e_cnt;
            end
        end
    end

    assign o_sts.scan_last = (r_scan_idx == REQ_W'(NREQ - 1));
    assign o_sts.out_free  = !r_out_valid || o_res.ready;

    // decide the item from the scan results
    always_comb begin
        seat_ok    = 1'b0;
        serve_hit  = 1'b0;
        res_status = lsf_pkg::ST_EMPTY;
        if (r_kind == lsf_pkg::KIND_SEAT) begin
            if (({1'b0, r_req} >= n_eff) || (r_cap_cnt >= r_limit)) begin
                res_status = lsf_pkg::ST_FINISHED;
            end else if (r_waiting[r_req]) begin
                res_status = lsf_pkg::ST_WAITING;
            end else if (r_occ >= r_num_seats) begin
                res_status = lsf_pkg::ST_FULL;
            end else begin
                res_status = lsf_pkg::ST_SEATED;
                seat_ok    = 1'b1;
            end
        end else if (r_found) begin
            res_status = lsf_pkg::ST_SERVED;
            serve_hit  = 1'b1;
        end
    end

    assign new_cnt     = (r_best_cnt == '1) ? r_best_cnt : r_best_cnt + CNT_W'(1);
    assign best_in_use = ({1'b0, r_best_idx} < n_eff);
    assign fc_sub      = serve_hit && best_in_use && (r_best_cnt >= r_limit);
    assign fc_add      = serve_hit && best_in_use && (new_cnt >= r_limit);
    assign fc_new      = r_fc + SEAT_W'(fc_add) - SEAT_W'(fc_sub);

    always_comb begin
        n_occ = r_occ;
        if (seat_ok) begin
            n_occ = r_occ + SEAT_W'(1);
        end else if (serve_hit && (r_occ != '0)) begin
            n_occ = r_occ - SEAT_W'(1);
        end
    end

    assign free_new = (r_num_seats > n_occ) ? (r_num_seats - n_occ) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= '0;
            r_cnt_valid <= '0;
            r_arr_ctr   <= '0;
            r_occ       <= '0;
        end else if (i_cmd.commit) begin
            r_occ <= n_occ;
            if (seat_ok) begin
                r_waiting[r_req] <= 1'b1;
                r_arr_ctr        <= r_arr_ctr + STAMP_W'(1);
            end
            if (serve_hit) begin
                r_waiting[r_best_idx]   <= 1'b0;
                r_cnt_valid[r_best_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= res_status;
            r_out_who    <= serve_hit ? r_best_idx : '0;
            r_out_cnt    <= serve_hit ? new_cnt : '0;
            r_out_free   <= free_new;
            r_out_fin    <= (fc_new == n_eff);
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_out_status;
    assign o_res.served_requester = r_out_who;
    assign o_res.served_count     = r_out_cnt;
    assign o_res.free_seats       = r_out_free;
    assign o_res.all_finished     = r_out_fin;

`ifndef ASSERT_OFF
    a_occ_matches_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == SEAT_W'($countones(r_waiting)))
        else $error("seat occupancy disagrees with waiting entries");

    a_commit_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not present a result");

    a_served_leaves_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && serve_hit) |=> !r_waiting[$past(r_best_idx)])
        else $error("served requester still waiting");

    a_commit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || o_res.ready))
        else $error("result overwritten before transaction");
`endif

endmodule

// ===== design/least_served_first_scheduler.sv =====
// Channel  | Dir | Fields                                              | Transaction
// i_req    | in  | kind, requester                                     | valid & ready
// o_res    | out | status, served_requester, served_count,             | valid & ready
//          |     | free_seats, all_finished                            |
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data                     | i_cfg_we
//
// Each item is accepted, swept against all 64 entries of the requester table
// through its single read port, drained from the read register, then committed.
// Commit waits while the previous result is still held on o_res.
// Reset is synchronous on i_rst_n and clears waiting and service-count valid bits.
// A new item is taken only once the previous one has committed.
module least_served_first_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lsf_req_if.sink                            i_req,
    lsf_res_if.source                          o_res
);

    lsf_pkg::t_ctl_cmd w_cmd;
    lsf_pkg::t_ctl_sts w_sts;
    logic              w_ready;

    assign i_req.ready = w_ready;

    lsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lsf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (i_req.kind),
        .i_requester (i_req.requester),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res       (o_res)
    );

endmodule
